// ===== rtl/core/acpr_pkg.sv =====
package acpr_pkg;

  localparam int NUM_BANKS = 2;
  localparam int PKT_WORDS = 36;
  localparam logic [15:0] SYNC_HEAD = 16'hABCD;
  localparam logic [15:0] SYNC_TAIL = 16'hDCBA;
  localparam logic [15:0] BANK_SPAN = 16'h0800;
  localparam logic [9:0] COUNT_MAX = 10'd1023;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [1:0] ST_WRITE = 2'd0;
  localparam logic [1:0] ST_SYNC = 2'd1;
  localparam logic [1:0] ST_CRC = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // verdict passed from the front part to the back part
  typedef struct packed {
    logic [1:0] status;
    logic [15:0] offset;
  } verdict_t;

  function automatic logic [15:0] xor_key(input logic [2:0] idx);
    logic [15:0] k;
    begin
      case (idx)
        3'd0: k = 16'h6C16;
        3'd1: k = 16'hE614;
        3'd2: k = 16'h912E;
        3'd3: k = 16'h400D;
        3'd4: k = 16'h3521;
        3'd5: k = 16'h40D5;
        3'd6: k = 16'h0313;
        default: k = 16'h80E9;
      endcase
      return k;
    end
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    begin
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
        c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
    end
  endfunction

endpackage

// ===== rtl/core/air_copy_packet_receiver.sv =====
// channel   | handshake      | fields
// input     | push / full    | mode, rx_word, modem_error
// result    | pop / empty    | status, write_address, write_data, last,
//           |                | good_blocks, bad_blocks, complete
// config    | cfg_we         | cfg_data (map_index)
// words 1 to 33 use S_RECV and S_CRC (one crc byte per cycle), others S_RECV;
// after the last word full stays high while the verdict waits in S_DONE
// a good packet then gives 32 results, one per cycle while pop is held
// reset: synchronous rst clears map select, position, counters and done flag
// full also holds at word 2 of the next packet until the back has sent its
// last result, as the payload buffer is shared; the back stalls on pop alone
module air_copy_packet_receiver (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic mode,
  input  logic [15:0] rx_word,
  input  logic modem_error,
  input  logic cfg_we,
  input  logic [3:0] cfg_data,
  output logic empty,
  input  logic pop,
  output logic [1:0] status,
  output logic [15:0] write_address,
  output logic [15:0] write_data,
  output logic last,
  output logic [9:0] good_blocks,
  output logic [9:0] bad_blocks,
  output logic complete
);
  import acpr_pkg::*;

  logic [3:0] map_index;
  logic in_ready, start, wr_pay;
  logic vq_valid, vq_ready, out_valid;
  verdict_t vq_data;
  logic [5:0] pos;
  logic [4:0] pl_idx;
  logic [15:0] pl_data;
  logic [15:0] payload [32];
  logic [15:0] dec_word;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) map_index <= '0;
    else if (cfg_we) map_index <= cfg_data;
  end

  // payload is not overwritten while the back still reads it
  assign full = !in_ready || (vq_valid) || (!vq_ready && pos == 6'd2);
  assign start = push && !full && mode;
  assign wr_pay = push && !full && !mode && pos >= 6'd2 && pos <= 6'd33;
  assign dec_word = rx_word ^ xor_key(3'(pos - 6'd1));

  // payload memory, one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_pay) payload[5'(pos - 6'd2)] <= dec_word;
    pl_data <= payload[pl_idx];
  end

  acpr_front u_front (
    .clk, .rst,
    .in_valid(push && !full && !mode), .in_ready,
    .rx_word, .modem_error, .start, .map_index,
    .vq_valid, .vq_ready, .vq_data, .pos_out(pos)
  );

  acpr_back u_back (
    .clk, .rst,
    .vq_valid, .vq_ready, .vq_data, .start, .map_index,
    .pl_data, .pl_idx,
    .out_valid, .out_ready(pop), .status, .write_address, .write_data, .last,
    .good_blocks, .bad_blocks, .complete
  );

  assign empty = !out_valid;

`ifndef SYNTHESIS
  a_rej_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_WRITE) |-> last) else $error("reject without last");
  a_rej_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_WRITE) |-> (write_address == 16'd0))
    else $error("reject address nonzero");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos < 6'(PKT_WORDS)) else $error("word position out of range");
`endif

endmodule

// ===== rtl/core/acpr_front.sv =====
module acpr_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [15:0] rx_word,
  input  logic modem_error,
  input  logic start,
  input  logic [3:0] map_index,
  output logic vq_valid,
  input  logic vq_ready,
  output acpr_pkg::verdict_t vq_data,
  output logic [5:0] pos_out
);
  import acpr_pkg::*;

  typedef enum logic [2:0] {
    S_RECV = 3'b001,
    S_CRC  = 3'b010,
    S_DONE = 3'b100
  } fstate_t;

  fstate_t state;
  logic [5:0] word_position;
  logic [15:0] crc;
  logic [15:0] offset;
  logic [1:0] status;
  logic head_ok, sync_bad;
  logic [7:0] hi_byte;
  logic [15:0] dec;
  logic [3:0] msel;
  logic in_map;
  logic [15:0] sa, sb, sc;

  assign in_ready = (state == S_RECV);
  assign pos_out = word_position;
  assign dec = rx_word ^ xor_key(3'(word_position - 6'd1));

  // map select and offset window test
  always_comb begin
    msel = (map_index > 4'(NUM_BANKS)) ? 4'd0 : map_index;
    sa = 16'(msel) * BANK_SPAN;
    sb = 16'h4000 + sa;
    sc = 16'h8000 + {4'd0, msel, 8'd0};
    if (msel == 4'(NUM_BANKS)) begin
      in_map = (offset >= 16'hA000 && offset < 16'hA170) ||
               (offset >= 16'h880E && offset < 16'h886E);
    end else begin
      in_map = (offset >= sa && {1'b0, offset} < {1'b0, sa} + 17'(BANK_SPAN)) ||
               (offset >= sb && {1'b0, offset} < {1'b0, sb} + 17'(BANK_SPAN)) ||
               (offset >= sc && {1'b0, offset} < {1'b0, sc} + 17'h100);
    end
  end

  assign vq_valid = (state == S_DONE);
  assign vq_data.status = (status == ST_WRITE && !in_map) ? ST_RANGE : status;
  assign vq_data.offset = offset;

  // word collection; crc runs one byte per cycle within a word, low byte in S_RECV, high byte in S_CRC
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RECV;
      word_position <= '0;
    end else begin
      case (state)
        S_RECV: begin
          if (start) begin
            word_position <= '0;
          end else if (in_valid) begin
            if (word_position == 6'd0) begin
              sync_bad <= (rx_word != SYNC_HEAD);
              crc <= '0;
              word_position <= 6'd1;
            end else if (word_position == 6'(PKT_WORDS - 1)) begin
              word_position <= '0;
              status <= (sync_bad || modem_error || rx_word != SYNC_TAIL) ? ST_SYNC :
                        (head_ok ? ST_WRITE : ST_CRC);
              state <= S_DONE;
            end else if (word_position == 6'd34) begin
              head_ok <= (dec == crc);
              word_position <= word_position + 6'd1;
            end else begin
              if (word_position == 6'd1) offset <= dec;
              crc <= crc_byte(crc, dec[7:0]);
              hi_byte <= dec[15:8];
              state <= S_CRC;
            end
          end
        end
        S_CRC: begin
          // high byte of the current word
          crc <= crc_byte(crc, hi_byte);
          word_position <= word_position + 6'd1;
          state <= S_RECV;
        end
        S_DONE: begin
          if (vq_ready) state <= S_RECV;
        end
        default: state <= S_RECV;
      endcase
    end
  end

endmodule

// ===== rtl/core/acpr_back.sv =====
module acpr_back (
  input  logic clk,
  input  logic rst,
  input  logic vq_valid,
  output logic vq_ready,
  input  acpr_pkg::verdict_t vq_data,
  input  logic start,
  input  logic [3:0] map_index,
  input  logic [15:0] pl_data,
  output logic [4:0] pl_idx,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] status,
  output logic [15:0] write_address,
  output logic [15:0] write_data,
  output logic last,
  output logic [9:0] good_blocks,
  output logic [9:0] bad_blocks,
  output logic complete
);
  import acpr_pkg::*;

  logic [9:0] acc, rej;
  logic done;
  logic busy;
  logic [1:0] st;
  logic [15:0] off;
  logic [4:0] idx, idx_next;
  logic [9:0] acc_next, rej_next;
  logic done_next;
  logic [9:0] acc_snap, rej_snap;
  logic done_snap;
  logic [10:0] total;
  logic [3:0] msel;
  logic take, emit;

  assign msel = (map_index > 4'(NUM_BANKS)) ? 4'd0 : map_index;
  assign total = (msel == 4'(NUM_BANKS)) ? 11'd8 : 11'd68;
  assign vq_ready = !busy;
  assign take = !busy && vq_valid;
  assign emit = busy && (!out_valid || out_ready);
  assign acc_next = (vq_data.status == ST_WRITE && acc != COUNT_MAX) ? acc + 10'd1 : acc;
  assign rej_next = (vq_data.status != ST_WRITE && rej != COUNT_MAX) ? rej + 10'd1 : rej;
  assign done_next = done || (({1'b0, acc_next} + {1'b0, rej_next}) >= total);

  // payload read address is idx_next, so the registered read data lines up with idx
  assign idx_next = take ? 5'd0 : (emit ? idx + 5'd1 : idx);
  assign pl_idx = idx_next;

  // verdict intake, counting, and result sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0; rej <= '0; done <= 1'b0;
      busy <= 1'b0; out_valid <= 1'b0; idx <= '0;
    end else begin
      idx <= idx_next;
      // counters; a new transfer clears them but leaves queued results alone
      if (start) begin
        acc <= '0; rej <= '0; done <= 1'b0;
      end else if (take) begin
        acc <= acc_next; rej <= rej_next; done <= done_next;
      end
      if (take) begin
        st <= vq_data.status; off <= vq_data.offset;
        acc_snap <= acc_next; rej_snap <= rej_next; done_snap <= done_next;
        busy <= 1'b1;
      end else if (emit) begin
        status <= st;
        last <= (st != ST_WRITE) || (idx == 5'd31);
        write_address <= (st == ST_WRITE) ? off + {10'd0, idx, 1'b0} : 16'd0;
        write_data <= (st == ST_WRITE) ? pl_data : 16'd0;
        good_blocks <= acc_snap; bad_blocks <= rej_snap; complete <= done_snap;
        if (st != ST_WRITE || idx == 5'd31) busy <= 1'b0;
      end
      // output register handshake
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule

// ===== tb/acpr_checker.sv =====
module acpr_checker (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic full,
  input  logic mode,
  input  logic [15:0] rx_word,
  input  logic modem_error,
  input  logic cfg_we,
  input  logic [3:0] cfg_data,
  input  logic empty,
  input  logic pop,
  input  logic [1:0] status,
  input  logic [15:0] write_address,
  input  logic [15:0] write_data,
  input  logic last,
  input  logic [9:0] good_blocks,
  input  logic [9:0] bad_blocks,
  input  logic complete,
  output int errors,
  output int pending,
  output int writes_seen,
  output int rejects_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import acpr_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [15:0] addr;
    logic [15:0] data;
    logic last;
    logic [9:0] good;
    logic [9:0] bad;
    logic done;
  } write_rec_t;

  write_rec_t expected_writes[$];
  logic [3:0] map_sel;
  int pos;
  logic [15:0] words[36];
  logic [9:0] good_cnt, bad_cnt;
  logic done_r;

  function automatic logic [15:0] key_word(int i);
    logic [15:0] keys[8] = '{16'h6C16, 16'hE614, 16'h912E, 16'h400D,
                             16'h3521, 16'h40D5, 16'h0313, 16'h80E9};
    return keys[i & 7];
  endfunction

  function automatic logic [15:0] crc8_step(logic [15:0] c, logic [7:0] b);
    c = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    return c;
  endfunction

  function automatic int active_map();
    return (map_sel > NUM_BANKS) ? 0 : map_sel;
  endfunction

  function automatic bit offset_ok(logic [15:0] off);
    int m;
    int o;
    m = active_map();
    o = off;
    if (m == NUM_BANKS)
      return (o >= 'hA000 && o < 'hA170) || (o >= 'h880E && o < 'h886E);
    return (o >= m * 'h800 && o < m * 'h800 + 'h800) ||
           (o >= 'h4000 + m * 'h800 && o < 'h4800 + m * 'h800) ||
           (o >= 'h8000 + m * 'h100 && o < 'h8100 + m * 'h100);
  endfunction

  function automatic void update_done();
    int total;
    total = (active_map() == NUM_BANKS) ? 8 : 68;
    if (int'(good_cnt) + int'(bad_cnt) >= total) done_r = 1'b1;
  endfunction

  function automatic void reject_packet(logic [1:0] st);
    write_rec_t r;
    if (bad_cnt < COUNT_MAX) bad_cnt++;
    update_done();
    r = '{st, 16'h0, 16'h0, 1'b1, good_cnt, bad_cnt, done_r};
    expected_writes.push_back(r);
  endfunction

  // predict results for one accepted item
  function automatic void predict_item(logic m, logic [15:0] w, logic merr);
    logic [15:0] plain[36];
    logic [15:0] crc;
    write_rec_t r;
    if (m) begin
      pos = 0; good_cnt = 0; bad_cnt = 0; done_r = 0;
      return;
    end
    words[pos] = w;
    pos++;
    if (pos < PKT_WORDS) return;
    pos = 0;
    if (merr || words[0] != SYNC_HEAD || words[35] != SYNC_TAIL) begin
      reject_packet(ST_SYNC);
      return;
    end
    crc = 16'h0;
    for (int k = 1; k <= 34; k++) plain[k] = words[k] ^ key_word(k - 1);
    for (int k = 1; k <= 33; k++) begin
      crc = crc8_step(crc, plain[k][7:0]);
      crc = crc8_step(crc, plain[k][15:8]);
    end
    if (plain[34] != crc) begin
      reject_packet(ST_CRC);
      return;
    end
    if (!offset_ok(plain[1])) begin
      reject_packet(ST_RANGE);
      return;
    end
    if (good_cnt < COUNT_MAX) good_cnt++;
    update_done();
    for (int i = 0; i < 32; i++) begin
      r = '{ST_WRITE, plain[1] + 16'(2 * i), plain[2 + i], 1'(i == 31),
            good_cnt, bad_cnt, done_r};
      expected_writes.push_back(r);
    end
  endfunction

  // watch both channels and compare
  always @(posedge clk) begin
    write_rec_t got, want;
    if (rst) begin
      map_sel <= 4'd0;
      pos = 0; good_cnt = 0; bad_cnt = 0; done_r = 0;
      expected_writes.delete();
      errors <= 0; writes_seen <= 0; rejects_seen <= 0;
    end else begin
      if (cfg_we) map_sel <= cfg_data;
      if (push && !full) predict_item(mode, rx_word, modem_error);
      if (pop && !empty) begin
        got = '{status, write_address, write_data, last, good_blocks, bad_blocks,
                complete};
        if (got.status == ST_WRITE) writes_seen <= writes_seen + 1;
        else rejects_seen <= rejects_seen + 1;
        if (expected_writes.size() == 0) begin
          if (errors < 10) $display("unexpected item: %p", got);
          errors <= errors + 1;
        end else begin
          want = expected_writes.pop_front();
          if (got !== want) begin
            if (errors < 10) $display("mismatch: expected %p got %p", want, got);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= expected_writes.size();
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import acpr_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0, mode = 1'b0, modem_error = 1'b0, cfg_we = 1'b0, pop = 1'b0;
  logic [15:0] rx_word = 16'h0;
  logic [3:0] cfg_data = 4'h0;
  logic full, empty, last, complete;
  logic [1:0] status;
  logic [15:0] write_address, write_data;
  logic [9:0] good_blocks, bad_blocks;
  int errors, pending, writes_seen, rejects_seen;
  int hold_off = 0;
  bit stim_done = 0;
  logic [15:0] pkt[36];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  air_copy_packet_receiver u_top (.*);
  acpr_checker u_chk (.*);

  // result side: random pop gaps, plus a long hold-off on request
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (hold_off > 0) begin
        gap = hold_off;
        hold_off = 0;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  task automatic send_item(logic m, logic [15:0] w, logic merr, bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    mode <= m;
    rx_word <= w;
    modem_error <= merr;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic wait_quiet();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_map(logic [3:0] v);
    wait_quiet();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] crc_add(logic [15:0] c, logic [7:0] b);
    c = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    return c;
  endfunction

  // build a packet; defect 0 none, 1 bad sync, 2 bad crc
  function automatic void build_packet(logic [15:0] off, int defect);
    logic [15:0] keys[8] = '{16'h6C16, 16'hE614, 16'h912E, 16'h400D,
                             16'h3521, 16'h40D5, 16'h0313, 16'h80E9};
    logic [15:0] plain[36];
    logic [15:0] c;
    c = 0;
    plain[1] = off;
    for (int k = 2; k <= 33; k++) plain[k] = 16'($urandom);
    for (int k = 1; k <= 33; k++) begin
      c = crc_add(c, plain[k][7:0]);
      c = crc_add(c, plain[k][15:8]);
    end
    plain[34] = (defect == 2) ? c ^ 16'(1 << $urandom_range(0, 15)) : c;
    pkt[0] = (defect == 1 && $urandom_range(0, 1)) ? 16'hABCC : SYNC_HEAD;
    pkt[35] = (defect == 1 && pkt[0] == SYNC_HEAD) ? 16'hDCBB : SYNC_TAIL;
    for (int k = 1; k <= 34; k++) pkt[k] = plain[k] ^ keys[(k - 1) & 7];
  endfunction

  function automatic logic [15:0] pick_offset(int m, bit inside_map);
    logic [15:0] segs[3];
    if (!inside_map) return 16'hF000 + 16'($urandom_range(0, 'hFFF));
    if (m == NUM_BANKS)
      return $urandom_range(0, 1) ? 16'hA000 + 16'($urandom_range(0, 'h16F))
                                  : 16'h880E + 16'($urandom_range(0, 'h5F));
    segs[0] = 16'(m * 'h800);
    segs[1] = 16'('h4000 + m * 'h800);
    segs[2] = 16'('h8000 + m * 'h100);
    case ($urandom_range(0, 3))
      0: return segs[0] + 16'h7FF;
      1: return segs[1] + 16'($urandom_range(0, 'h7FF));
      2: return segs[2] + 16'($urandom_range(0, 'hFF));
      default: return segs[0];
    endcase
  endfunction

  task automatic send_packet(int m, int defect, bit inside_map, logic merr, bit idle);
    build_packet(pick_offset(m, inside_map), defect);
    for (int k = 0; k < 36; k++) send_item(1'b0, pkt[k], (k == 35) ? merr : ~merr, idle);
  endtask

  // stimulus
  initial begin
    int m;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: one packet of each kind
    send_item(1'b1, 16'hFFFF, 1'b1, 1);
    send_packet(0, 0, 1, 1'b0, 1);
    send_packet(0, 0, 1, 1'b1, 1);
    send_packet(0, 1, 1, 1'b0, 1);
    send_packet(0, 2, 1, 1'b0, 0);
    send_packet(0, 0, 0, 1'b0, 1);
    // long receiver stall while sender keeps going
    hold_off = 300;
    send_packet(0, 0, 1, 1'b0, 0);
    send_packet(0, 0, 1, 1'b0, 0);
    // settings map, then selectors beyond the valid range
    for (int phase = 0; phase < 3; phase++) begin
      m = (phase == 0) ? NUM_BANKS : (phase == 1) ? 15 : 8;
      write_map(4'(m));
      if (m > NUM_BANKS) m = 0;
      send_item(1'b1, 16'($urandom), 1'($urandom), 1);
      case ($urandom_range(0, 9))
        0: send_packet(m, 1, 1, 1'b0, 1);
        1: send_packet(m, 2, 1, 1'b0, 1);
        2: send_packet(m, 0, 0, 1'b0, 1);
        3: send_packet(m, 0, 1, 1'b1, 1);
        4: for (int k = 0; k < 5; k++) send_item(1'b0, 16'($urandom), 1'b0, 1);
        default: send_packet(m, 0, 1, 1'b0, ($urandom_range(0, 2) != 0));
      endcase
      // realign the word position for the next phase
      send_item(1'b1, 16'h0, 1'b0, 1);
    end
    write_map(4'd0);
    wait_quiet();
    stim_done = 1;
  end

  // verdict
  initial begin
    @(posedge clk);
    wait (stim_done);
    $display("covered %0d writes and %0d rejections over several map settings",
             writes_seen, rejects_seen);
    if (errors == 0 && pending == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== air_copy_packet_receiver.f =====
rtl/core/acpr_pkg.sv
rtl/core/acpr_front.sv
rtl/core/acpr_back.sv
rtl/core/air_copy_packet_receiver.sv
tb/acpr_checker.sv
tb/tb.sv
